// File: hdl/rtat_pkg.sv
// ----------------------------------------------------------------------------
// rtat_pkg: shared constants and types for the run-time average tracker
// Window sizing, divider sizing, timeout constants and controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package rtat_pkg;

    // window geometry
    localparam int WINDOW_DEPTH = 5;
    localparam int NUM_WIN      = 3;
    localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    // field widths
    localparam int SAMPLE_W   = 32;
    localparam int MEAN_OUT_W = 31;
    localparam int TMO_MS_W   = 16;
    localparam int TMO_US_W   = 26;

    // sum and divider sizing: radix-16 restoring divider
    localparam int SUM_W          = SAMPLE_W + CNT_W;
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_STEPS      = (SUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int DIV_W          = DIV_STEPS * DIV_RADIX_BITS;
    localparam int DSTEP_W        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // window selectors
    localparam int WIN_W = 2;
    localparam logic [WIN_W-1:0] WIN_ALL  = 2'd0;
    localparam logic [WIN_W-1:0] WIN_MAIN = 2'd1;
    localparam logic [WIN_W-1:0] WIN_PREV = 2'd2;

    // request codes
    localparam logic       CMD_RECORD = 1'b0;
    localparam logic       CMD_INIT   = 1'b1;
    localparam logic [1:0] SLOT_MAIN  = 2'd0;
    localparam logic [1:0] SLOT_PREV  = 2'd1;

    // ceil(x / 1000) via x + 999 then multiply by reciprocal, valid for 32-bit x
    localparam logic [SAMPLE_W-1:0] ROUND_UP_MS = 32'd999;
    localparam int                  RECIP_W     = 29;
    localparam logic [RECIP_W-1:0]  RECIP_1000  = 29'h10624DD3;
    localparam int                  RECIP_SHIFT = 38;
    localparam int                  PROD_W      = SAMPLE_W + RECIP_W;
    localparam int                  RT_W        = PROD_W - RECIP_SHIFT;
    localparam logic [9:0]          US_PER_MS   = 10'd1000;

    // configuration port
    localparam int   ADDR_W              = 3;
    localparam int   DATA_W              = 32;
    localparam logic REG_IDX_USER_TIMEOUT = 1'b0;

    typedef struct packed {
        logic capture;
        logic init;
        logic push;
        logic use_slot;
        logic sum_step;
        logic div_load;
        logic div_step;
        logic mean_write;
        logic tmo_add;
        logic tmo_mul;
        logic tmo_min;
        logic tmo_us;
        logic out_load;
    } rtat_cmd_t;

    typedef struct packed {
        logic is_init;
        logic is_push;
        logic sum_last;
        logic div_last;
        logic out_free;
    } rtat_status_t;

endpackage

// File: hdl/rtat_ctrl.sv
// ----------------------------------------------------------------------------
// rtat_ctrl: sequencer for the run-time average tracker
// Steps one request through window update, summing and division (records only), and timeout.
// ----------------------------------------------------------------------------
module rtat_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  rtat_pkg::rtat_status_t status,
    output rtat_pkg::rtat_cmd_t    cmd_o
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DECODE = 11'b000_0000_0010,
        S_SUM    = 11'b000_0000_0100,
        S_DLOAD  = 11'b000_0000_1000,
        S_DIV    = 11'b000_0001_0000,
        S_MWRITE = 11'b000_0010_0000,
        S_TADD   = 11'b000_0100_0000,
        S_TMUL   = 11'b000_1000_0000,
        S_TMIN   = 11'b001_0000_0000,
        S_TUS    = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;   // 0: overall window, 1: slot window

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd_o      = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_o.capture = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.is_init)
                begin
                    cmd_o.init = 1'b1;
                    state_next = S_TADD;
                end
                else if (status.is_push)
                begin
                    cmd_o.push = 1'b1;
                    phase_next = 1'b0;
                    state_next = S_SUM;
                end
                else
                begin
                    state_next = S_TADD;
                end
            end
            S_SUM:
            begin
                cmd_o.sum_step = 1'b1;
                cmd_o.use_slot = phase_reg;
                if (status.sum_last)
                begin
                    state_next = S_DLOAD;
                end
            end
            S_DLOAD:
            begin
                cmd_o.div_load = 1'b1;
                cmd_o.use_slot = phase_reg;
                state_next     = S_DIV;
            end
            S_DIV:
            begin
                cmd_o.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_MWRITE;
                end
            end
            S_MWRITE:
            begin
                cmd_o.mean_write = 1'b1;
                cmd_o.use_slot   = phase_reg;
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    state_next = S_SUM;
                end
                else
                begin
                    state_next = S_TADD;
                end
            end
            S_TADD:
            begin
                cmd_o.tmo_add = 1'b1;
                state_next    = S_TMUL;
            end
            S_TMUL:
            begin
                cmd_o.tmo_mul = 1'b1;
                state_next    = S_TMIN;
            end
            S_TMIN:
            begin
                cmd_o.tmo_min = 1'b1;
                state_next    = S_TUS;
            end
            S_TUS:
            begin
                cmd_o.tmo_us = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd_o.out_load = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/rtat_dp.sv
// ----------------------------------------------------------------------------
// rtat_dp: datapath of the run-time average tracker
// Sample windows, accumulator, radix-16 divider, timeout arithmetic and
// the output register.
// ----------------------------------------------------------------------------
module rtat_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rtat_pkg::rtat_cmd_t                  cmd_i,
    output rtat_pkg::rtat_status_t               status,
    input  logic                                 cmd,
    input  logic [1:0]                           slot,
    input  logic [rtat_pkg::SAMPLE_W-1:0]        sample_us,
    input  logic [rtat_pkg::TMO_MS_W-1:0]        user_limit_ms,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [rtat_pkg::MEAN_OUT_W-1:0]      avg_all_us,
    output logic [rtat_pkg::MEAN_OUT_W-1:0]      avg_main_us,
    output logic [rtat_pkg::MEAN_OUT_W-1:0]      avg_preview_us,
    output logic [rtat_pkg::TMO_MS_W-1:0]        throttle_ms,
    output logic [rtat_pkg::TMO_US_W-1:0]        timeout_us
);

    localparam int SW = rtat_pkg::SAMPLE_W;
    localparam int MW = rtat_pkg::MEAN_OUT_W;
    localparam int CW = rtat_pkg::CNT_W;
    localparam int IW = rtat_pkg::IDX_W;
    localparam int DW = rtat_pkg::DIV_W;
    localparam int ND = rtat_pkg::WINDOW_DEPTH;
    localparam int NW = rtat_pkg::NUM_WIN;

    // captured request
    logic          item_cmd_reg;
    logic [1:0]    item_slot_reg;
    logic [SW-1:0] item_sample_reg;

    // window state
    logic [SW-1:0] win_reg  [NW][ND];
    logic [CW-1:0] cnt_reg  [NW];
    logic [IW-1:0] pos_reg  [NW];
    logic [SW-1:0] mean_reg [NW];

    logic [IW-1:0] pos_safe [NW];
    logic [IW-1:0] pos_inc  [NW];
    logic [CW-1:0] cnt_inc  [NW];

    // accumulator and divider
    logic [rtat_pkg::SUM_W-1:0]   sum_reg;
    logic [IW-1:0]                idx_reg;
    logic [DW-1:0]                dvd_reg, dvd_next;
    logic [CW-1:0]                rem_reg, rem_next;
    logic [CW-1:0]                dvs_reg;
    logic [rtat_pkg::DSTEP_W-1:0] dstep_reg;

    // timeout pipeline
    logic [SW-1:0]                  x_reg;
    logic                           avg_zero_reg;
    logic [rtat_pkg::PROD_W-1:0]    prod_reg;
    logic [rtat_pkg::RT_W-1:0]      rt;
    logic [rtat_pkg::TMO_MS_W-1:0]  tmo_ms_reg;
    logic [rtat_pkg::TMO_US_W-1:0]  tmo_us_reg;

    // output register
    logic                          out_valid_reg;
    logic [MW-1:0]                 out_all_reg, out_main_reg, out_prev_reg;
    logic [rtat_pkg::TMO_MS_W-1:0] out_ms_reg;
    logic [rtat_pkg::TMO_US_W-1:0] out_us_reg;

    logic [rtat_pkg::WIN_W-1:0] slot_win, cur_win;
    logic [CW-1:0]              cur_cnt;
    logic [MW-1:0]              rd_all, rd_main, rd_prev;

    // means of 2^31 or more read as zero
    function automatic logic [MW-1:0] read_mean(input logic [SW-1:0] m);
        return m[SW-1] ? '0 : m[MW-1:0];
    endfunction

    assign slot_win = (item_slot_reg == rtat_pkg::SLOT_MAIN) ? rtat_pkg::WIN_MAIN
                                                             : rtat_pkg::WIN_PREV;
    assign cur_win  = cmd_i.use_slot ? slot_win : rtat_pkg::WIN_ALL;
    assign cur_cnt  = cnt_reg[cur_win];

    assign rd_all  = read_mean(mean_reg[rtat_pkg::WIN_ALL]);
    assign rd_main = read_mean(mean_reg[rtat_pkg::WIN_MAIN]);
    assign rd_prev = read_mean(mean_reg[rtat_pkg::WIN_PREV]);

    always_comb
    begin
        for (int w = 0; w < NW; w++)
        begin
            pos_safe[w] = (int'(pos_reg[w]) >= ND) ? '0 : pos_reg[w];
            pos_inc[w]  = (int'(pos_safe[w]) == ND - 1) ? '0 : pos_safe[w] + IW'(1);
            cnt_inc[w]  = (int'(cnt_reg[w]) < ND) ? cnt_reg[w] + CW'(1) : cnt_reg[w];
        end
    end

    // status back to the sequencer
    assign status.is_init  = (item_cmd_reg == rtat_pkg::CMD_INIT);
    assign status.is_push  = (item_cmd_reg == rtat_pkg::CMD_RECORD)
                             && (item_sample_reg != '0)
                             && ((item_slot_reg == rtat_pkg::SLOT_MAIN)
                                 || (item_slot_reg == rtat_pkg::SLOT_PREV));
    assign status.sum_last = ((CW'(idx_reg) + CW'(1)) == cur_cnt);
    assign status.div_last = (dstep_reg == rtat_pkg::DSTEP_W'(rtat_pkg::DIV_STEPS - 1));
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd_i.capture)
        begin
            item_cmd_reg    <= cmd;
            item_slot_reg   <= slot;
            item_sample_reg <= sample_us;
        end
    end

    // windows, counts, ring positions and means
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NW; w++)
            begin
                cnt_reg[w]  <= '0;
                pos_reg[w]  <= '0;
                mean_reg[w] <= '0;
                for (int i = 0; i < ND; i++)
                begin
                    win_reg[w][i] <= '0;
                end
            end
        end
        else if (cmd_i.init)
        begin
            for (int w = 0; w < NW; w++)
            begin
                mean_reg[w] <= item_sample_reg;
                if (item_sample_reg != '0)
                begin
                    cnt_reg[w] <= CW'(ND);
                    pos_reg[w] <= '0;
                    for (int i = 0; i < ND; i++)
                    begin
                        win_reg[w][i] <= item_sample_reg;
                    end
                end
            end
        end
        else if (cmd_i.push)
        begin
            win_reg[rtat_pkg::WIN_ALL][pos_safe[rtat_pkg::WIN_ALL]] <= item_sample_reg;
            cnt_reg[rtat_pkg::WIN_ALL] <= cnt_inc[rtat_pkg::WIN_ALL];
            pos_reg[rtat_pkg::WIN_ALL] <= pos_inc[rtat_pkg::WIN_ALL];
            win_reg[slot_win][pos_safe[slot_win]] <= item_sample_reg;
            cnt_reg[slot_win] <= cnt_inc[slot_win];
            pos_reg[slot_win] <= pos_inc[slot_win];
        end
        else if (cmd_i.mean_write)
        begin
            mean_reg[cur_win] <= dvd_reg[SW-1:0];
        end
    end

    // restoring divider, four quotient bits per cycle
    always_comb
    begin
        logic [CW:0]   r;
        logic [DW-1:0] d;
        r = {1'b0, rem_reg};
        d = dvd_reg;
        for (int k = 0; k < rtat_pkg::DIV_RADIX_BITS; k++)
        begin
            r = {r[CW-1:0], d[DW-1]};
            d = {d[DW-2:0], 1'b0};
            if (r >= {1'b0, dvs_reg})
            begin
                r    = r - {1'b0, dvs_reg};
                d[0] = 1'b1;
            end
        end
        rem_next = r[CW-1:0];
        dvd_next = d;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.capture || cmd_i.div_load)
        begin
            sum_reg <= '0;
            idx_reg <= '0;
        end
        else if (cmd_i.sum_step)
        begin
            sum_reg <= sum_reg + rtat_pkg::SUM_W'(win_reg[cur_win][idx_reg]);
            idx_reg <= idx_reg + IW'(1);
        end

        if (cmd_i.div_load)
        begin
            dvd_reg   <= DW'(sum_reg);
            rem_reg   <= '0;
            dvs_reg   <= (cur_cnt == '0) ? CW'(1) : cur_cnt;
            dstep_reg <= '0;
        end
        else if (cmd_i.div_step)
        begin
            dvd_reg   <= dvd_next;
            rem_reg   <= rem_next;
            dstep_reg <= dstep_reg + rtat_pkg::DSTEP_W'(1);
        end
    end

    // timeout: ceil(mean / 1000), capped by the user limit; the user limit when the mean is zero
    assign rt = prod_reg[rtat_pkg::PROD_W-1:rtat_pkg::RECIP_SHIFT];

    always_ff @(posedge clk)
    begin
        if (cmd_i.tmo_add)
        begin
            x_reg        <= {1'b0, rd_all} + rtat_pkg::ROUND_UP_MS;
            avg_zero_reg <= (rd_all == '0);
        end
        if (cmd_i.tmo_mul)
        begin
            prod_reg <= rtat_pkg::PROD_W'(x_reg) * rtat_pkg::PROD_W'(rtat_pkg::RECIP_1000);
        end
        if (cmd_i.tmo_min)
        begin
            if (avg_zero_reg || (rtat_pkg::RT_W'(user_limit_ms) < rt))
            begin
                tmo_ms_reg <= user_limit_ms;
            end
            else
            begin
                tmo_ms_reg <= rt[rtat_pkg::TMO_MS_W-1:0];
            end
        end
        if (cmd_i.tmo_us)
        begin
            tmo_us_reg <= rtat_pkg::TMO_US_W'(tmo_ms_reg)
                          * rtat_pkg::TMO_US_W'(rtat_pkg::US_PER_MS);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_i.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.out_load)
        begin
            out_all_reg  <= rd_all;
            out_main_reg <= rd_main;
            out_prev_reg <= rd_prev;
            out_ms_reg   <= tmo_ms_reg;
            out_us_reg   <= tmo_us_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign avg_all_us     = out_all_reg;
    assign avg_main_us    = out_main_reg;
    assign avg_preview_us = out_prev_reg;
    assign throttle_ms    = out_ms_reg;
    assign timeout_us     = out_us_reg;

endmodule

// File: hdl/runtime_average_timeout_tracker.sv
// ----------------------------------------------------------------------------
// runtime_average_timeout_tracker: moving-average run-time and timeout tracker
// Sequence: init and ignored requests go from decode straight to the timeout steps;
//   a record first sums, divides and writes the overall window, then the slot window.
// Requests: one in flight at a time, through the shared sum/divide sequence; a
//   parked result that waits for out_ready holds off the next request.
// Reset: rst_n asynchronous, clears windows, counts, positions, means and the limit.
// ----------------------------------------------------------------------------
module runtime_average_timeout_tracker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 cmd,
    input  logic [1:0]                           slot,
    input  logic [rtat_pkg::SAMPLE_W-1:0]        sample_us,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [rtat_pkg::MEAN_OUT_W-1:0]      avg_all_us,
    output logic [rtat_pkg::MEAN_OUT_W-1:0]      avg_main_us,
    output logic [rtat_pkg::MEAN_OUT_W-1:0]      avg_preview_us,
    output logic [rtat_pkg::TMO_MS_W-1:0]        throttle_ms,
    output logic [rtat_pkg::TMO_US_W-1:0]        timeout_us,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rtat_pkg::ADDR_W-1:0]          paddr,
    input  logic [rtat_pkg::DATA_W-1:0]          pwdata,
    output logic [rtat_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    rtat_pkg::rtat_cmd_t    dp_cmd;
    rtat_pkg::rtat_status_t dp_status;

    // user limit on the timeout in ms; zero forces a zero timeout
    logic [rtat_pkg::TMO_MS_W-1:0] user_timeout_reg;
    logic                          reg_hit;
    logic                          cfg_write;

    // register i sits at byte address 4*i; only the word index bit is decoded
    assign reg_hit   = (paddr[2] == rtat_pkg::REG_IDX_USER_TIMEOUT);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = reg_hit ? rtat_pkg::DATA_W'(user_timeout_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_timeout_reg <= '0;
        end
        else if (cfg_write && reg_hit)
        begin
            user_timeout_reg <= pwdata[rtat_pkg::TMO_MS_W-1:0];
        end
    end

    // sequencer: one request in flight, result parked in the output register
    rtat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (dp_status),
        .cmd_o    (dp_cmd)
    );

    // windows, sum, divider and timeout arithmetic
    rtat_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_i           (dp_cmd),
        .status          (dp_status),
        .cmd             (cmd),
        .slot            (slot),
        .sample_us       (sample_us),
        .user_limit_ms   (user_timeout_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .avg_all_us      (avg_all_us),
        .avg_main_us     (avg_main_us),
        .avg_preview_us  (avg_preview_us),
        .throttle_ms     (throttle_ms),
        .timeout_us      (timeout_us)
    );

    // a taken request keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready high right after a request was taken");

    // a new result only appears after the block has been working on a request
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a request in progress");

    // the microsecond timeout always tracks the millisecond one
    a_us_matches_ms: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (timeout_us == rtat_pkg::TMO_US_W'(throttle_ms)
                                     * rtat_pkg::TMO_US_W'(rtat_pkg::US_PER_MS)))
        else $error("timeout_us does not equal throttle_ms times 1000");

endmodule
